// File: design/lac_pkg.sv
// Shared types, constants and helper functions for the lazy admission cache policy.
// Used by every module of the block; it depends on nothing else.
package lac_pkg;

    localparam int REGULAR_ENTRIES = 1024;
    localparam int GHOST_ENTRIES   = 1024;
    localparam int BLOCK_BITS      = 32;

    localparam int R_IDX_W = $clog2(REGULAR_ENTRIES);
    localparam int G_IDX_W = $clog2(GHOST_ENTRIES);
    localparam int R_CNT_W = $clog2(REGULAR_ENTRIES + 1);
    localparam int G_CNT_W = $clog2(GHOST_ENTRIES + 1);

    localparam int CAP_W   = 11;
    localparam int SLOT_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGULAR_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd2;

    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT,
        OUT_GHOST,
        OUT_MISS
    } outcome_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_READ,
        ACC_WRITE
    } access_t;

    // One queued access after classification.
    typedef struct packed {
        logic                  wr;
        logic [BLOCK_BITS-1:0] blk;
        logic                  last;
    } lac_item_t;

    typedef struct packed {
        outcome_t              outcome;
        access_t               ssd_access;
        logic [SLOT_W-1:0]     ssd_slot;
        access_t               backing_access;
        logic                  writeback_valid;
        logic [BLOCK_BITS-1:0] writeback_block;
        logic                  last_block;
    } lac_result_t;

    // Capacity as used by the lists: zero acts as one, and it never exceeds the storage.
    function automatic logic [R_CNT_W-1:0] reg_cap(input logic [CAP_W-1:0] cap);
        logic [R_CNT_W-1:0] res;
        if (cap == '0)
            res = R_CNT_W'(1);
        else if (32'(cap) > REGULAR_ENTRIES)
            res = R_CNT_W'(REGULAR_ENTRIES);
        else
            res = R_CNT_W'(cap);
        return res;
    endfunction

    function automatic logic [G_CNT_W-1:0] ghost_cap(input logic [CAP_W-1:0] cap);
        logic [G_CNT_W-1:0] res;
        if (cap == '0)
            res = G_CNT_W'(1);
        else if (32'(cap) > GHOST_ENTRIES)
            res = G_CNT_W'(GHOST_ENTRIES);
        else
            res = G_CNT_W'(cap);
        return res;
    endfunction

endpackage

// File: design/lac_mod.sv
// Iterative remainder unit: one restoring step per cycle.
// Depends on lac_pkg for the slot width.
module lac_mod
    import lac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SLOT_W-1:0] dividend,
    input  logic [SLOT_W-1:0] divisor,
    output logic              done,
    output logic [SLOT_W-1:0] remainder
);

    localparam int STEP_W = $clog2(SLOT_W + 1);

    logic [SLOT_W-1:0] rem_reg;
    logic [SLOT_W-1:0] dvd_reg;
    logic [SLOT_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [SLOT_W:0]   trial;
    logic [SLOT_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[SLOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            if (divisor == '0)
            begin
                // A zero slot count leaves the block number unreduced.
                rem_reg  <= dividend;
                step_reg <= '0;
                done_reg <= 1'b1;
            end
            else
            begin
                rem_reg  <= '0;
                step_reg <= STEP_W'(SLOT_W);
                done_reg <= 1'b0;
            end
        end
        else if (step_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_reg <= diff[SLOT_W-1:0];
            else
                rem_reg <= trial[SLOT_W-1:0];
            dvd_reg  <= {dvd_reg[SLOT_W-2:0], 1'b0};
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
                done_reg <= 1'b1;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: design/lac_front.sv
// Front end: accepts accesses, classifies them and holds them in a two-entry queue.
// Depends on lac_pkg for the item type.
module lac_front
    import lac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  req_type,
    input  logic [BLOCK_BITS-1:0] block_number,
    input  logic                  request_last,
    output logic                  head_valid,
    output lac_item_t             head,
    input  logic                  pop
);

    lac_item_t  q_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign req_ready  = (cnt_reg != 2'd2);
    assign push       = req_valid && req_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].wr   <= (req_type == REQ_WRITE);
            q_reg[wr_ptr_reg].blk  <= block_number;
            q_reg[wr_ptr_reg].last <= request_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// File: design/lac_back.sv
// Back end: searches and reorders the regular and ghost lists, holds the result register.
// Depends on lac_pkg and instantiates lac_mod for the slot remainder.
module lac_back
    import lac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  lac_item_t        head,
    output logic             pop,
    input  logic [CAP_W-1:0] regular_capacity,
    input  logic [CAP_W-1:0] ghost_capacity,
    input  logic [SLOT_W-1:0] ssd_slot_count,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lac_result_t      result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSCAN,
        S_GSCAN,
        S_SHIFT,
        S_ADMIT,
        S_TAIL,
        S_MISS,
        S_FRONT,
        S_FIN
    } state_t;

    state_t                state_reg;
    lac_item_t             item_reg;
    outcome_t              outcome_reg;
    logic                  front_dirty_reg;
    logic                  sh_ghost_reg;
    logic                  pend_reg;
    logic                  wb_valid_reg;
    logic [BLOCK_BITS-1:0] wb_block_reg;
    logic [R_CNT_W-1:0]    rcount_reg;
    logic [G_CNT_W-1:0]    gcount_reg;
    logic [R_CNT_W-1:0]    r_n_reg;
    logic [G_CNT_W-1:0]    g_n_reg;
    logic [R_IDX_W-1:0]    r_src_reg;
    logic [R_IDX_W-1:0]    r_dst_reg;
    logic [G_IDX_W-1:0]    g_src_reg;
    logic [G_IDX_W-1:0]    g_dst_reg;
    logic                  rsp_valid_reg;
    lac_result_t           result_reg;

    // Regular entries carry the dirty bit above the tag.
    logic [BLOCK_BITS:0]   rmem [REGULAR_ENTRIES];
    logic [BLOCK_BITS-1:0] gmem [GHOST_ENTRIES];
    logic [BLOCK_BITS:0]   r_rdata_reg;
    logic [BLOCK_BITS-1:0] g_rdata_reg;

    logic [R_IDX_W-1:0]    r_raddr;
    logic [R_IDX_W-1:0]    r_waddr;
    logic [BLOCK_BITS:0]   r_wdata;
    logic                  r_we;
    logic [G_IDX_W-1:0]    g_raddr;
    logic [G_IDX_W-1:0]    g_waddr;
    logic [BLOCK_BITS-1:0] g_wdata;
    logic                  g_we;

    logic [R_CNT_W-1:0]    rcap_eff;
    logic [G_CNT_W-1:0]    gcap_eff;
    logic [G_CNT_W-1:0]    gc_kept;
    logic                  shift_up;
    logic                  div_done;
    logic [SLOT_W-1:0]     div_rem;
    access_t               ssd_acc;
    access_t               back_acc;

    assign rcap_eff = reg_cap(regular_capacity);
    assign gcap_eff = ghost_cap(ghost_capacity);
    assign gc_kept  = (gcount_reg >= gcap_eff && gcount_reg != '0) ?
                      gcount_reg - G_CNT_W'(1) : gcount_reg;
    assign shift_up = sh_ghost_reg && (outcome_reg == OUT_GHOST);
    assign pop      = (state_reg == S_IDLE) && head_valid;

    lac_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pop),
        .dividend  (SLOT_W'(head.blk)),
        .divisor   (ssd_slot_count),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Memory addressing follows the current step.
    always_comb
    begin
        r_raddr = r_src_reg;
        g_raddr = g_src_reg;
        case (state_reg)
            S_RSCAN: r_raddr = r_n_reg[R_IDX_W-1:0];
            S_GSCAN: g_raddr = g_n_reg[G_IDX_W-1:0];
            S_ADMIT: r_raddr = R_IDX_W'(rcount_reg - R_CNT_W'(1));
            default: ;
        endcase

        r_we    = 1'b0;
        r_waddr = r_dst_reg;
        r_wdata = r_rdata_reg;
        g_we    = 1'b0;
        g_waddr = g_dst_reg;
        g_wdata = g_rdata_reg;
        if (state_reg == S_SHIFT && pend_reg)
        begin
            r_we = !sh_ghost_reg;
            g_we = sh_ghost_reg;
        end
        if (state_reg == S_FRONT)
        begin
            if (outcome_reg == OUT_MISS)
            begin
                g_we    = 1'b1;
                g_waddr = '0;
                g_wdata = item_reg.blk;
            end
            else
            begin
                r_we    = 1'b1;
                r_waddr = '0;
                r_wdata = {front_dirty_reg, item_reg.blk};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            rmem[r_waddr] <= r_wdata;
        r_rdata_reg <= rmem[r_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            gmem[g_waddr] <= g_wdata;
        g_rdata_reg <= gmem[g_raddr];
    end

    always_comb
    begin
        ssd_acc  = ACC_NONE;
        back_acc = ACC_NONE;
        case (outcome_reg)
            OUT_HIT:   ssd_acc = item_reg.wr ? ACC_WRITE : ACC_READ;
            OUT_GHOST:
            begin
                ssd_acc  = ACC_WRITE;
                back_acc = item_reg.wr ? ACC_NONE : ACC_READ;
            end
            default:   back_acc = item_reg.wr ? ACC_WRITE : ACC_READ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            outcome_reg     <= OUT_MISS;
            front_dirty_reg <= 1'b0;
            sh_ghost_reg    <= 1'b0;
            pend_reg        <= 1'b0;
            wb_valid_reg    <= 1'b0;
            wb_block_reg    <= '0;
            rcount_reg      <= '0;
            gcount_reg      <= '0;
            r_n_reg         <= '0;
            g_n_reg         <= '0;
            r_src_reg       <= '0;
            r_dst_reg       <= '0;
            g_src_reg       <= '0;
            g_dst_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            // A result taken in the same cycle as the next one is loaded stays valid.
            if (rsp_valid_reg && rsp_ready && !(state_reg == S_FIN && div_done))
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        item_reg     <= head;
                        wb_valid_reg <= 1'b0;
                        wb_block_reg <= '0;
                        pend_reg     <= 1'b0;
                        r_n_reg      <= '0;
                        g_n_reg      <= '0;
                        if (rcount_reg != '0)
                            state_reg <= S_RSCAN;
                        else if (gcount_reg != '0)
                            state_reg <= S_GSCAN;
                        else
                            state_reg <= S_MISS;
                    end
                end
                S_RSCAN:
                begin
                    if (pend_reg && r_rdata_reg[BLOCK_BITS-1:0] == item_reg.blk)
                    begin
                        outcome_reg     <= OUT_HIT;
                        front_dirty_reg <= r_rdata_reg[BLOCK_BITS] | item_reg.wr;
                        r_src_reg       <= r_dst_reg - R_IDX_W'(1);
                        r_n_reg         <= R_CNT_W'(r_dst_reg);
                        pend_reg        <= 1'b0;
                        sh_ghost_reg    <= 1'b0;
                        state_reg       <= S_SHIFT;
                    end
                    else if (r_n_reg < rcount_reg)
                    begin
                        pend_reg  <= 1'b1;
                        r_dst_reg <= r_n_reg[R_IDX_W-1:0];
                        r_n_reg   <= r_n_reg + R_CNT_W'(1);
                    end
                    else if (pend_reg)
                        pend_reg <= 1'b0;
                    else
                    begin
                        g_n_reg   <= '0;
                        state_reg <= (gcount_reg != '0) ? S_GSCAN : S_MISS;
                    end
                end
                S_GSCAN:
                begin
                    if (pend_reg && g_rdata_reg == item_reg.blk)
                    begin
                        outcome_reg  <= OUT_GHOST;
                        gcount_reg   <= gcount_reg - G_CNT_W'(1);
                        g_src_reg    <= g_dst_reg + G_IDX_W'(1);
                        g_n_reg      <= gcount_reg - G_CNT_W'(1) - G_CNT_W'(g_dst_reg);
                        pend_reg     <= 1'b0;
                        sh_ghost_reg <= 1'b1;
                        state_reg    <= S_SHIFT;
                    end
                    else if (g_n_reg < gcount_reg)
                    begin
                        pend_reg  <= 1'b1;
                        g_dst_reg <= g_n_reg[G_IDX_W-1:0];
                        g_n_reg   <= g_n_reg + G_CNT_W'(1);
                    end
                    else if (pend_reg)
                        pend_reg <= 1'b0;
                    else
                        state_reg <= S_MISS;
                end
                S_SHIFT:
                begin
                    // One entry moves per cycle: read the source, write it one place on.
                    if (sh_ghost_reg)
                    begin
                        if (g_n_reg != '0)
                        begin
                            g_dst_reg <= shift_up ? g_src_reg - G_IDX_W'(1)
                                                  : g_src_reg + G_IDX_W'(1);
                            g_src_reg <= shift_up ? g_src_reg + G_IDX_W'(1)
                                                  : g_src_reg - G_IDX_W'(1);
                            g_n_reg   <= g_n_reg - G_CNT_W'(1);
                            pend_reg  <= 1'b1;
                        end
                        else
                            pend_reg <= 1'b0;
                        if (g_n_reg == '0 && !pend_reg)
                            state_reg <= shift_up ? S_ADMIT : S_FRONT;
                    end
                    else
                    begin
                        if (r_n_reg != '0)
                        begin
                            r_dst_reg <= r_src_reg + R_IDX_W'(1);
                            r_src_reg <= r_src_reg - R_IDX_W'(1);
                            r_n_reg   <= r_n_reg - R_CNT_W'(1);
                            pend_reg  <= 1'b1;
                        end
                        else
                            pend_reg <= 1'b0;
                        if (r_n_reg == '0 && !pend_reg)
                            state_reg <= S_FRONT;
                    end
                end
                S_ADMIT:
                begin
                    front_dirty_reg <= item_reg.wr;
                    sh_ghost_reg    <= 1'b0;
                    pend_reg        <= 1'b0;
                    if (rcount_reg >= rcap_eff && rcount_reg != '0)
                        state_reg <= S_TAIL;
                    else
                    begin
                        r_n_reg   <= rcount_reg;
                        r_src_reg <= R_IDX_W'(rcount_reg - R_CNT_W'(1));
                        state_reg <= S_SHIFT;
                    end
                end
                S_TAIL:
                begin
                    if (r_rdata_reg[BLOCK_BITS])
                    begin
                        wb_valid_reg <= 1'b1;
                        wb_block_reg <= r_rdata_reg[BLOCK_BITS-1:0];
                    end
                    rcount_reg <= rcount_reg - R_CNT_W'(1);
                    r_n_reg    <= rcount_reg - R_CNT_W'(1);
                    r_src_reg  <= R_IDX_W'(rcount_reg - R_CNT_W'(2));
                    state_reg  <= S_SHIFT;
                end
                S_MISS:
                begin
                    outcome_reg  <= OUT_MISS;
                    gcount_reg   <= gc_kept;
                    g_n_reg      <= gc_kept;
                    g_src_reg    <= G_IDX_W'(gc_kept - G_CNT_W'(1));
                    sh_ghost_reg <= 1'b1;
                    pend_reg     <= 1'b0;
                    state_reg    <= S_SHIFT;
                end
                S_FRONT:
                begin
                    if (outcome_reg == OUT_GHOST)
                        rcount_reg <= rcount_reg + R_CNT_W'(1);
                    else if (outcome_reg == OUT_MISS)
                        gcount_reg <= gcount_reg + G_CNT_W'(1);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (div_done && (!rsp_valid_reg || rsp_ready))
                    begin
                        result_reg.outcome         <= outcome_reg;
                        result_reg.ssd_access      <= ssd_acc;
                        result_reg.ssd_slot        <= (ssd_acc != ACC_NONE) ? div_rem : '0;
                        result_reg.backing_access  <= back_acc;
                        result_reg.writeback_valid <= wb_valid_reg;
                        result_reg.writeback_block <= wb_block_reg;
                        result_reg.last_block      <= item_reg.last;
                        rsp_valid_reg              <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_rcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rcount_reg) <= REGULAR_ENTRIES)
        else $error("regular list count beyond storage");
    a_gcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(gcount_reg) <= GHOST_ENTRIES)
        else $error("ghost list count beyond storage");
    a_wb_only_admit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && result_reg.writeback_valid |-> result_reg.outcome == OUT_GHOST)
        else $error("writeback reported without an admission");
    a_miss_no_ssd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && result_reg.outcome == OUT_MISS |-> result_reg.ssd_access == ACC_NONE)
        else $error("miss reported a cache device access");
`endif

endmodule

// File: design/lazy_admission_cache_policy.sv
// Top level of the lazy admission cache policy: configuration registers and the
// front and back ends. Depends on lac_pkg, lac_front and lac_back.
//
// Usage: each item on the request channel (req_valid/req_ready) is one block access:
// req_type, block_number and request_last. Each item yields exactly one item on the
// response channel (rsp_valid/rsp_ready) with the outcome, the cache device and
// backing store accesses, the cache slot, any dirty writeback and a copy of
// request_last. Responses come back in request order.
// A two-entry queue in the front end accepts new items while the back end works.
// The back end scans the regular list, then the ghost list, one entry per cycle
// from memories with one read and one write port, then moves entries one per cycle
// to reorder a list. The slot remainder runs alongside the scan. Reset empties
// both lists and loads the capacities and slot count with 1024. Configuration
// writes (cfg_valid/cfg_ready, always ready) should come only while no item is
// in flight; the block itself does not enforce this. When the receiver stalls, the
// finished result waits in the output register and the back end holds until it
// is taken.
module lazy_admission_cache_policy
    import lac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  req_type,
    input  logic [BLOCK_BITS-1:0] block_number,
    input  logic                  request_last,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [1:0]            outcome,
    output logic [1:0]            ssd_access,
    output logic [SLOT_W-1:0]     ssd_slot,
    output logic [1:0]            backing_access,
    output logic                  writeback_valid,
    output logic [BLOCK_BITS-1:0] writeback_block,
    output logic                  last_block,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [CAP_W-1:0]  regular_capacity_reg;
    logic [CAP_W-1:0]  ghost_capacity_reg;
    logic [SLOT_W-1:0] ssd_slot_count_reg;

    logic        head_valid;
    lac_item_t   head;
    logic        pop;
    lac_result_t result;

    assign cfg_ready = 1'b1;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regular_capacity_reg <= CAP_W'(1024);
            ghost_capacity_reg   <= CAP_W'(1024);
            ssd_slot_count_reg   <= SLOT_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REGULAR_CAP: regular_capacity_reg <= cfg_data[CAP_W-1:0];
                CFG_GHOST_CAP:   ghost_capacity_reg   <= cfg_data[CAP_W-1:0];
                CFG_SLOT_COUNT:  ssd_slot_count_reg   <= cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    lac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .block_number (block_number),
        .request_last (request_last),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    lac_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .regular_capacity (regular_capacity_reg),
        .ghost_capacity   (ghost_capacity_reg),
        .ssd_slot_count   (ssd_slot_count_reg),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .result           (result)
    );

    assign outcome         = result.outcome;
    assign ssd_access      = result.ssd_access;
    assign ssd_slot        = result.ssd_slot;
    assign backing_access  = result.backing_access;
    assign writeback_valid = result.writeback_valid;
    assign writeback_block = result.writeback_block;
    assign last_block      = result.last_block;

endmodule
